>>> sv/gnt_pkg.sv
// ----------------------------------------------------------------------------
// gnt_pkg
// Shared types and constants of the gradient noise turbulence block.
// ----------------------------------------------------------------------------
package gnt_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TAB_AW     = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 24;
  localparam int GRAD_W     = 48;
  localparam int OCT_CFG_W  = 5;

  localparam logic       ACT_LOAD  = 1'b0;
  localparam logic       ACT_EVAL  = 1'b1;
  localparam logic       CFG_OCT   = 1'b0;
  localparam logic       CFG_ABS   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERM,
    ST_CORN,
    ST_DRAIN,
    ST_OCT,
    ST_FIN
  } gnt_state_t;

endpackage

>>> sv/gnt_ram.sv
// ----------------------------------------------------------------------------
// gnt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/gradient_noise_turbulence_core.sv
// ----------------------------------------------------------------------------
// gradient_noise_turbulence_core
// Fixed point 3D gradient noise summed over octaves, with optional absolute.
// ----------------------------------------------------------------------------
// A load request writes one entry of the permutation and gradient RAMs in the
// cycle it is taken and yields no result. An evaluate request runs one octave
// at a time, with the octave count reset to 7: reading the six permutation
// bytes of the lattice cell, issuing one gradient RAM read per corner,
// draining the four stage corner multiply pipeline and adding the octave in.
// The single read port of each table RAM makes these reads go one after
// another. One request is worked on at a time; a new request is taken while
// a finished result still waits at the output register.
module gradient_noise_turbulence_core #(
  parameter int MAX_OCTAVES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [7:0]                     in_table_index,
  input  logic [7:0]                     in_perm_x_entry,
  input  logic [7:0]                     in_perm_y_entry,
  input  logic [7:0]                     in_perm_z_entry,
  input  logic signed [15:0]             in_gradient_x,
  input  logic signed [15:0]             in_gradient_y,
  input  logic signed [15:0]             in_gradient_z,
  input  logic signed [31:0]             in_point_x,
  input  logic signed [31:0]             in_point_y,
  input  logic signed [31:0]             in_point_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [19:0]             out_noise_value,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [gnt_pkg::OCT_CFG_W-1:0]  cfg_wdata
);

  import gnt_pkg::*;

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int CMP_W = (OCT_W > OCT_CFG_W) ? OCT_W : OCT_CFG_W;

  gnt_state_t state_r, state_nxt;
  logic [2:0]           cnt_r;
  logic [OCT_W-1:0]     oct_r, n_r;
  logic [OCT_CFG_W-1:0] oct_cfg_r;
  logic                 abs_r;
  logic [31:0]          pt_r [3];
  logic [31:0]          ff_r [3];
  logic [16:0]          g_r  [3];
  logic [7:0]           pb_r [6];
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [2:0]           c1_r, c2_r;
  logic signed [33:0]   p_r [3];
  logic [33:0]          w01_r;
  logic signed [35:0]   dot_r;
  logic [34:0]          wt_r;
  logic signed [55:0]   prod_r;
  logic signed [59:0]   acc_r;
  logic signed [31:0]   sum_r;
  logic                 out_valid_r;
  logic signed [19:0]   out_noise_r;

  logic                 in_acc;
  logic                 fin_go;
  logic [CMP_W-1:0]     n_cmp;
  logic [OCT_W-1:0]     n_new;
  logic [1:0]           rd_axis;
  logic [15:0]          rd_coord;
  logic [TAB_AW-1:0]    perm_raddr, grad_raddr;
  logic [PERM_W-1:0]    perm_q;
  logic [GRAD_W-1:0]    grad_q;
  logic [2:0]           cap_j;
  logic [7:0]           cap_byte;
  logic [7:0]           hash;
  logic [16:0]          w_x1, w_y1, w_z2;
  logic signed [17:0]   d [3];
  logic signed [15:0]   gq [3];
  logic signed [59:0]   acc_sh, oct_sh;
  logic signed [31:0]   sum_mag;
  logic signed [19:0]   res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_noise_value = out_noise_r;
  assign fin_go    = !out_valid_r || out_ready;

  // octave count saturated to the supported maximum
  always_comb begin
    n_cmp = CMP_W'(oct_cfg_r);
    if (n_cmp > CMP_W'(MAX_OCTAVES)) begin
      n_cmp = CMP_W'(MAX_OCTAVES);
    end
    n_new = n_cmp[OCT_W-1:0];
  end

  // table RAMs
  always_comb begin
    rd_axis  = (cnt_r[2:1] == 2'd3) ? 2'd2 : cnt_r[2:1];
    rd_coord = pt_r[rd_axis][31:16] + 16'(cnt_r[0]);
    perm_raddr = rd_coord[TAB_AW-1:0];
    hash = (cnt_r[2] ? pb_r[1] : pb_r[0]) ^ (cnt_r[1] ? pb_r[3] : pb_r[2]) ^
           (cnt_r[0] ? pb_r[5] : pb_r[4]);
    grad_raddr = hash[TAB_AW-1:0];
  end

  gnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_ram (
    .clk   (clk),
    .we    (in_acc && in_action == ACT_LOAD),
    .waddr (in_table_index[TAB_AW-1:0]),
    .wdata ({in_perm_z_entry, in_perm_y_entry, in_perm_x_entry}),
    .raddr (perm_raddr),
    .rdata (perm_q)
  );

  gnt_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_grad_ram (
    .clk   (clk),
    .we    (in_acc && in_action == ACT_LOAD),
    .waddr (in_table_index[TAB_AW-1:0]),
    .wdata ({in_gradient_z, in_gradient_y, in_gradient_x}),
    .raddr (grad_raddr),
    .rdata (grad_q)
  );

  always_comb begin
    cap_j = cnt_r - 3'd1;
    case (cap_j[2:1])
      2'd0:    cap_byte = perm_q[7:0];
      2'd1:    cap_byte = perm_q[15:8];
      default: cap_byte = perm_q[23:16];
    endcase
  end

  // fade weights, registered through ff_r and then g_r after the point changes
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ff_r[a] <= pt_r[a][15:0] * pt_r[a][15:0];
      g_r[a]  <= 17'((50'(ff_r[a]) *
                 50'(18'd196608 - {1'b0, pt_r[a][15:0], 1'b0})) >> 32);
    end
  end

  // corner datapath
  always_comb begin
    gq[0] = grad_q[15:0];
    gq[1] = grad_q[31:16];
    gq[2] = grad_q[47:32];
    for (int a = 0; a < 3; a++) begin
      d[a] = c1_r[2-a] ? $signed({2'b11, pt_r[a][15:0]})
                       : $signed({2'b00, pt_r[a][15:0]});
    end
    w_x1 = c1_r[2] ? g_r[0] : 17'd65536 - g_r[0];
    w_y1 = c1_r[1] ? g_r[1] : 17'd65536 - g_r[1];
    w_z2 = c2_r[0] ? g_r[2] : 17'd65536 - g_r[2];
    acc_sh = acc_r >>> 30;
    oct_sh = acc_sh >>> oct_r;
  end

  always_ff @(posedge clk) begin
    c1_r <= cnt_r;
    c2_r <= c1_r;
    for (int a = 0; a < 3; a++) begin
      p_r[a] <= gq[a] * d[a];
    end
    w01_r  <= w_x1 * w_y1;
    dot_r  <= 36'(p_r[0]) + 36'(p_r[1]) + 36'(p_r[2]);
    wt_r   <= w01_r[33:16] * w_z2;
    prod_r <= $signed({1'b0, wt_r[34:16]}) * dot_r;
  end

  // final magnitude and saturation
  always_comb begin
    sum_mag = (abs_r && sum_r < 0) ? -sum_r : sum_r;
    if (sum_mag > 32'sd524287) begin
      res = 20'sh7FFFF;
    end else if (sum_mag < -32'sd524288) begin
      res = 20'sh80000;
    end else begin
      res = sum_mag[19:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_action == ACT_EVAL) begin
          state_nxt = (n_new == '0) ? ST_FIN : ST_PERM;
        end
      end
      ST_PERM:  if (cnt_r == 3'd6) state_nxt = ST_CORN;
      ST_CORN:  if (cnt_r == 3'd7) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!(v1_r || v2_r || v3_r || v4_r)) state_nxt = ST_OCT;
      ST_OCT:   state_nxt = (oct_r + 1'b1 == n_r) ? ST_FIN : ST_PERM;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      oct_r       <= '0;
      n_r         <= '0;
      oct_cfg_r   <= OCT_CFG_W'(7);
      abs_r       <= 1'b1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_CORN);
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      if (cfg_we) begin
        if (cfg_index == CFG_OCT) begin
          oct_cfg_r <= cfg_wdata;
        end else begin
          abs_r <= cfg_wdata[0];
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (in_acc) begin
        oct_r <= '0;
        n_r   <= n_new;
      end else if (state_r == ST_OCT) begin
        oct_r <= oct_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r[0] <= in_point_x;
      pt_r[1] <= in_point_y;
      pt_r[2] <= in_point_z;
      sum_r   <= '0;
    end
    if (state_r == ST_PERM) begin
      if (cnt_r == 3'd0) begin
        acc_r <= '0;
      end else begin
        pb_r[cap_j] <= cap_byte;
      end
    end
    if (v4_r) begin
      acc_r <= acc_r + 60'(prod_r);
    end
    if (state_r == ST_OCT) begin
      sum_r <= sum_r + $signed(oct_sh[31:0]);
      for (int a = 0; a < 3; a++) begin
        pt_r[a] <= {pt_r[a][30:0], 1'b0};
      end
    end
    if (state_r == ST_FIN && fin_go) begin
      out_noise_r <= res;
    end
  end

  // the corner pipeline is empty whenever an octave is closed or a request taken
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OCT || in_ready) |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("corner pipeline busy outside an octave");

  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PERM || state_r == ST_CORN || state_r == ST_DRAIN ||
     state_r == ST_OCT) |-> (oct_r < n_r))
    else $error("octave counter beyond octave count");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fin_go) |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished request not presented");

endmodule

>>> tb/gradient_noise_turbulence_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_noise_turbulence_core_test
// Loads the permutation and gradient tables, evaluates noise at directed and
// random points over several octave and absolute settings, and checks every
// noise value against a bit-true predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence_core_test;
  import gnt_pkg::*;

  typedef struct {
    logic        action;
    logic [7:0]  idx;
    logic [7:0]  px, py, pz;
    logic [15:0] gx, gy, gz;
    logic [31:0] ptx, pty, ptz;
  } noise_req_t;

  class noise_scoreboard;
    logic [7:0]  perm_x[256], perm_y[256], perm_z[256];
    longint      grad_x[256], grad_y[256], grad_z[256];
    int unsigned octaves = 7;
    bit          absolute = 1;
    logic [19:0] pending_noise[$];
    int          errors = 0;

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    // both factors are non-negative and the product stays below 2^51
    function longint fade_weight(longint f);
      longint ff, h;
      ff = f * f;
      h = 3 * 65536 - 2 * f;
      return (ff * h) >> 32;
    endfunction

    function longint lattice_octave(logic [31:0] p[3]);
      longint fr[3], g[3], w[3], wt, dot, acc;
      logic [15:0] ip[3];
      logic [7:0] h, cidx;
      int b;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
        ip[a] = p[a][31:16];
        fr[a] = p[a][15:0];
        g[a] = fade_weight(fr[a]);
      end
      for (int c = 0; c < 8; c++) begin
        h = 0;
        dot = 0;
        for (int a = 0; a < 3; a++) begin
          b = (c >> (2 - a)) & 1;
          w[a] = b ? g[a] : 65536 - g[a];
          cidx = 8'(ip[a] + 16'(b));
          h ^= (a == 0) ? perm_x[cidx] : (a == 1) ? perm_y[cidx] : perm_z[cidx];
        end
        for (int a = 0; a < 3; a++) begin
          b = (c >> (2 - a)) & 1;
          dot += ((a == 0) ? grad_x[h] : (a == 1) ? grad_y[h] : grad_z[h])
                 * (fr[a] - (b ? 65536 : 0));
        end
        wt = (((w[0] * w[1]) >> 16) * w[2]) >> 16;
        acc += wt * dot;
      end
      return floor_shr(acc, 30);
    endfunction

    function void note_request(noise_req_t r);
      logic [31:0] p[3];
      longint sum;
      int unsigned n;
      if (r.action == ACT_LOAD) begin
        perm_x[r.idx] = r.px;
        perm_y[r.idx] = r.py;
        perm_z[r.idx] = r.pz;
        grad_x[r.idx] = longint'($signed(r.gx));
        grad_y[r.idx] = longint'($signed(r.gy));
        grad_z[r.idx] = longint'($signed(r.gz));
        return;
      end
      p[0] = r.ptx;
      p[1] = r.pty;
      p[2] = r.ptz;
      sum = 0;
      n = (octaves > 16) ? 16 : octaves;
      for (int k = 0; k < n; k++) begin
        sum += floor_shr(lattice_octave(p), k);
        for (int a = 0; a < 3; a++) p[a] = p[a] << 1;
      end
      if (absolute && sum < 0) sum = -sum;
      if (sum > 524287) sum = 524287;
      if (sum < -524288) sum = -524288;
      pending_noise.push_back(sum[19:0]);
    endfunction

    function void check_noise(logic [19:0] got);
      logic [19:0] want;
      if (pending_noise.size() == 0) begin
        $display("%0t: unexpected noise value %0d", $time, $signed(got));
        errors++;
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        $display("%0t: noise_value expected %0d actual %0d", $time,
                 $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_action;
  logic [7:0] in_table_index, in_perm_x_entry, in_perm_y_entry, in_perm_z_entry;
  logic signed [15:0] in_gradient_x, in_gradient_y, in_gradient_z;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic out_valid, out_ready;
  logic signed [19:0] out_noise_value;
  logic cfg_we, cfg_index;
  logic [OCT_CFG_W-1:0] cfg_wdata;

  noise_scoreboard sb = new();
  bit   hold_off = 0;

  gradient_noise_turbulence_core DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  // valid stays up into the next request when the gap drawn is zero
  task automatic send_request(noise_req_t r);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1;
    in_action       <= r.action;
    in_table_index  <= r.idx;
    in_perm_x_entry <= r.px;
    in_perm_y_entry <= r.py;
    in_perm_z_entry <= r.pz;
    in_gradient_x   <= r.gx;
    in_gradient_y   <= r.gy;
    in_gradient_z   <= r.gz;
    in_point_x      <= r.ptx;
    in_point_y      <= r.pty;
    in_point_z      <= r.ptz;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic noise_req_t load_req(logic [7:0] i);
    noise_req_t r;
    r.action = ACT_LOAD;
    r.idx = i;
    r.px = 8'($urandom);
    r.py = 8'($urandom);
    r.pz = 8'($urandom);
    r.gx = rand_grad();
    r.gy = rand_grad();
    r.gz = rand_grad();
    r.ptx = $urandom;
    r.pty = $urandom;
    r.ptz = $urandom;
    return r;
  endfunction

  function automatic noise_req_t eval_req(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    noise_req_t r;
    r = load_req(8'($urandom));
    r.action = ACT_EVAL;
    r.ptx = x;
    r.pty = y;
    r.ptz = z;
    return r;
  endfunction

  task automatic write_cfg(logic idx, logic [OCT_CFG_W-1:0] val);
    in_valid <= 0;
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_OCT) sb.octaves = val;
    else sb.absolute = val[0];
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_noise(out_noise_value);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
        out_ready <= 1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  initial begin
    noise_req_t r;
    int wait_cnt;
    in_valid = 0; in_action = 0; in_table_index = 0;
    in_perm_x_entry = 0; in_perm_y_entry = 0; in_perm_z_entry = 0;
    in_gradient_x = 0; in_gradient_y = 0; in_gradient_z = 0;
    in_point_x = 0; in_point_y = 0; in_point_z = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill every entry so no evaluation reads an unwritten one
    for (int i = 0; i < 256; i++) begin
      r = load_req(8'(i));
      if (i == 0) begin
        r.px = 8'hFF; r.py = 8'hFF; r.pz = 8'hFF;
        r.gx = 16'h4000; r.gy = 16'hC000; r.gz = 16'h4000;
      end
      if (i == 1) begin
        r.px = 0; r.py = 0; r.pz = 0;
        r.gx = 16'hC000; r.gy = 16'h4000; r.gz = 16'hC000;
      end
      send_request(r);
    end

    // directed points, first at reset configuration, then at other octave and absolute settings
    send_request(eval_req(0, 0, 0));
    send_request(eval_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_request(eval_req(32'h80000000, 32'h80000000, 32'h80000000));
    send_request(eval_req(32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0000));
    send_request(eval_req(32'h00008000, 32'h00018000, 32'hFFFF8000));
    send_request(eval_req(32'hFFFFFFFF, 0, 32'h7FFFFFFF));
    write_cfg(CFG_OCT, 0);
    send_request(eval_req(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F));
    write_cfg(CFG_OCT, 1);
    write_cfg(CFG_ABS, 0);
    send_request(eval_req(32'h00008000, 32'h00004000, 32'h0000C000));
    send_request(eval_req(32'hFFFF7000, 32'h00011000, 32'h7FFF8000));
    write_cfg(CFG_OCT, 31);
    send_request(eval_req(32'h00012345, 32'hFFFE5432, 32'h00030303));
    write_cfg(CFG_OCT, 16);
    write_cfg(CFG_ABS, 1);
    send_request(eval_req(32'h00012345, 32'hFFFE5432, 32'h00030303));
    write_cfg(CFG_OCT, 17);
    send_request(eval_req(32'h00070005, 32'h000A0003, 32'h00B00B00));

    // long receiver hold-off while requests keep coming
    hold_off = 1;
    for (int i = 0; i < 6; i++)
      send_request(eval_req($urandom, $urandom, $urandom));

    // random phases, each with its own setting; mostly few octaves
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_OCT, (ph == 7) ? 5'd16 : 5'($urandom_range(0, 5)));
      write_cfg(CFG_ABS, ph[0]);
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 4) == 0) send_request(load_req(8'($urandom)));
        else send_request(eval_req($urandom, $urandom, $urandom));
      end
    end
    in_valid <= 0;

    wait_cnt = 0;
    while (sb.pending_noise.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_noise.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
